### rtl/core/stack_machine_executor_top_assert.svh
// ----------------------------------------------------------------------------
// stack_machine_executor_top_assert.svh
// Assertion macros shared by the stack machine executor RTL.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTOR_TOP_ASSERT_SVH
`define STACK_MACHINE_EXECUTOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SMX_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smx assertion failed");

// Next-cycle implication, disabled during reset
`define SMX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smx assertion failed");

`endif

### rtl/core/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg
// Types and constants of the stack machine executor.
// ----------------------------------------------------------------------------
package smx_pkg;

   localparam int DATA_W        = 64;
   localparam int PC_W          = 17;
   localparam int OP_W          = 5;
   localparam int STEP_W        = $clog2(DATA_W);
   localparam int PROGRAM_LIMIT = 65536;

   localparam logic [DATA_W-1:0] SIGN_MASK = {1'b1, {(DATA_W-1){1'b0}}};

   // Opcodes
   localparam logic [OP_W-1:0] OP_PUSH  = 5'd0;
   localparam logic [OP_W-1:0] OP_POP   = 5'd1;
   localparam logic [OP_W-1:0] OP_ADD   = 5'd2;
   localparam logic [OP_W-1:0] OP_SUB   = 5'd3;
   localparam logic [OP_W-1:0] OP_MUL   = 5'd4;
   localparam logic [OP_W-1:0] OP_DIV   = 5'd5;
   localparam logic [OP_W-1:0] OP_MOD   = 5'd6;
   localparam logic [OP_W-1:0] OP_LT    = 5'd7;
   localparam logic [OP_W-1:0] OP_LE    = 5'd8;
   localparam logic [OP_W-1:0] OP_GT    = 5'd9;
   localparam logic [OP_W-1:0] OP_GE    = 5'd10;
   localparam logic [OP_W-1:0] OP_EQ    = 5'd11;
   localparam logic [OP_W-1:0] OP_NE    = 5'd12;
   localparam logic [OP_W-1:0] OP_LOAD  = 5'd13;
   localparam logic [OP_W-1:0] OP_STASH = 5'd14;
   localparam logic [OP_W-1:0] OP_JUMP  = 5'd15;
   localparam logic [OP_W-1:0] OP_JZ    = 5'd16;
   localparam logic [OP_W-1:0] OP_EMIT  = 5'd17;
   localparam logic [OP_W-1:0] OP_HALT  = 5'd18;

   typedef enum logic [3:0] {
      ST_OK         = 4'd0,
      ST_HALTED     = 4'd1,
      ST_OVERFLOW   = 4'd2,
      ST_UNDERFLOW  = 4'd3,
      ST_BAD_SLOT   = 4'd4,
      ST_BAD_TARGET = 4'd5,
      ST_DIV_ZERO   = 4'd6,
      ST_MOD_ZERO   = 4'd7,
      ST_BAD_OP     = 4'd8,
      ST_RAN_OFF    = 4'd9,
      ST_STOPPED    = 4'd10
   } status_type;

   typedef enum logic [3:0] {
      ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV, ALU_MOD,
      ALU_SLT, ALU_SGE, ALU_EQ, ALU_NE
   } alu_op_type;

   typedef enum logic [2:0] {
      AL_IDLE, AL_NEGA, AL_NEGB, AL_ITER, AL_FIX, AL_DONE
   } alu_state_type;

   typedef enum logic [3:0] {
      EX_CLEAR, EX_IDLE, EX_DECODE, EX_RDB, EX_RDA, EX_ALU, EX_WAIT,
      EX_LOAD, EX_STORE, EX_POPTOP, EX_FINISH
   } ex_state_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_cmd_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] result;
   } alu_rsp_type;

endpackage

### rtl/core/stack_machine_executor_top.sv
// ----------------------------------------------------------------------------
// stack_machine_executor_top
// Stack bytecode interpreter core: one instruction per request transaction,
// one response transaction per instruction.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  req     | req_valid / req_stall  | req_opcode, req_operand
//  rsp     | rsp_valid / rsp_stall  | rsp_status, rsp_next_pc, rsp_print_*
//  csr     | csr_valid / csr_ready  | csr_data (program length)
//
// Push, pop, jump, halt and decode faults go from decode straight to finish;
// load, store, print, jump-if-zero and a zero divisor pass one more state;
// add, sub and compares wait on the ALU; mul and div/mod too, its shared adder
// stepping one bit a cycle. After reset the slot memory is zeroed with req
// stalled. One response is buffered; a second waits while rsp stalls.
// ----------------------------------------------------------------------------
module stack_machine_executor_top #(
   parameter int STACK_DEPTH = 256,
   parameter int SLOT_COUNT  = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [4:0]         req_opcode,
   input  logic signed [63:0] req_operand,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_status,
   output logic [16:0]        rsp_next_pc,
   output logic               rsp_print_valid,
   output logic signed [63:0] rsp_print_value,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [16:0]        csr_data
);

   import smx_pkg::*;

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int SAW   = $clog2(STACK_DEPTH);
   localparam int SLAW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   ex_state_type      state_ff, state_in, dec_next;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [DATA_W-1:0] arg_ff, arg_in;
   logic [DATA_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, cnt_m1, cnt_m2;
   logic [PC_W-1:0]   pc_ff, pc_in, npc_ff, npc_in, len_ff, len_in;
   logic              stop_ff, stop_in;
   status_type        status_ff, status_in, dec_status;
   logic              pvalid_ff, pvalid_in;
   logic [DATA_W-1:0] pval_ff, pval_in;
   logic [SLAW-1:0]   clr_ff, clr_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [PC_W-1:0]   rsp_npc_ff, rsp_npc_in;
   logic              rsp_pv_ff, rsp_pv_in;
   logic [DATA_W-1:0] rsp_pval_ff, rsp_pval_in;

   logic              stk_we, slot_we;
   logic [SAW-1:0]    stk_wa, stk_ra;
   logic [SLAW-1:0]   slot_wa;
   logic [DATA_W-1:0] stk_wd, stk_rd, slot_wd, slot_rd;

   alu_cmd_type       alu_cmd;
   alu_rsp_type       alu_rsp;
   alu_op_type        alu_op;
   logic              alu_swap;

   logic              req_take, rsp_free, stk_full, stk_empty;
   logic              slot_ok, target_ok, div_zero;

   // Handshakes
   assign req_stall = (state_ff != EX_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // Stack and range checks
   assign cnt_m1    = cnt_ff - CNT_W'(1);
   assign cnt_m2    = cnt_ff - CNT_W'(2);
   assign stk_full  = (cnt_ff == CNT_W'(STACK_DEPTH));
   assign stk_empty = (cnt_ff == '0);
   assign slot_ok   = (arg_ff < 64'(SLOT_COUNT));
   assign target_ok = (arg_ff[DATA_W-1:PC_W] == '0) && (arg_ff[PC_W-1:0] < len_ff);
   assign div_zero  = ((op_ff == OP_DIV) || (op_ff == OP_MOD)) && (stk_rd == '0);
   assign stk_ra    = (state_ff == EX_RDB) ? cnt_m2[SAW-1:0] : cnt_m1[SAW-1:0];

   // Memories
   smx_ram #(.DEPTH(STACK_DEPTH), .AW(SAW)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wa),
      .wr_data (stk_wd),
      .rd_addr (stk_ra),
      .rd_data (stk_rd)
   );

   smx_ram #(.DEPTH(SLOT_COUNT), .AW(SLAW)) u_slots (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_wa),
      .wr_data (slot_wd),
      .rd_addr (arg_ff[SLAW-1:0]),
      .rd_data (slot_rd)
   );

   // ALU operation and operand order
   always_comb begin
      alu_op   = ALU_ADD;
      alu_swap = 1'b0;
      unique case (op_ff)
         OP_ADD:  alu_op = ALU_ADD;
         OP_SUB:  alu_op = ALU_SUB;
         OP_MUL:  alu_op = ALU_MUL;
         OP_DIV:  alu_op = ALU_DIV;
         OP_MOD:  alu_op = ALU_MOD;
         OP_LT:   alu_op = ALU_SLT;
         OP_LE: begin
            alu_op   = ALU_SGE;
            alu_swap = 1'b1;
         end
         OP_GT: begin
            alu_op   = ALU_SLT;
            alu_swap = 1'b1;
         end
         OP_GE:   alu_op = ALU_SGE;
         OP_EQ:   alu_op = ALU_EQ;
         OP_NE:   alu_op = ALU_NE;
         default: alu_op = ALU_ADD;
      endcase
   end

   assign alu_cmd.start = (state_ff == EX_ALU);
   assign alu_cmd.op    = alu_op;

   smx_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .a     (alu_swap ? b_ff : a_ff),
      .b     (alu_swap ? a_ff : b_ff),
      .rsp   (alu_rsp)
   );

   // Instruction decode: immediate faults and the path to take
   always_comb begin
      dec_status = ST_OK;
      dec_next   = EX_FINISH;
      if (stop_ff) begin
         dec_status = ST_STOPPED;
      end else if (pc_ff >= len_ff) begin
         dec_status = ST_RAN_OFF;
      end else begin
         unique case (op_ff)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_LT, OP_LE, OP_GT, OP_GE,
            OP_EQ, OP_NE: begin
               if (cnt_ff < CNT_W'(2)) begin
                  dec_status = ST_UNDERFLOW;
               end else begin
                  dec_next = EX_RDB;
               end
            end
            OP_PUSH: begin
               if (stk_full) dec_status = ST_OVERFLOW;
            end
            OP_POP: begin
               if (stk_empty) dec_status = ST_UNDERFLOW;
            end
            OP_LOAD: begin
               if (!slot_ok) dec_status = ST_BAD_SLOT;
               else if (stk_full) dec_status = ST_OVERFLOW;
               else dec_next = EX_LOAD;
            end
            OP_STASH: begin
               if (!slot_ok) dec_status = ST_BAD_SLOT;
               else if (stk_empty) dec_status = ST_UNDERFLOW;
               else dec_next = EX_STORE;
            end
            OP_JUMP: begin
               if (!target_ok) dec_status = ST_BAD_TARGET;
            end
            OP_JZ, OP_EMIT: begin
               if (stk_empty) dec_status = ST_UNDERFLOW;
               else dec_next = EX_POPTOP;
            end
            OP_HALT: dec_status = ST_HALTED;
            default: dec_status = ST_BAD_OP;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         EX_CLEAR:  if (clr_ff == SLAW'(SLOT_COUNT - 1)) state_in = EX_IDLE;
         EX_IDLE:   if (req_take) state_in = EX_DECODE;
         EX_DECODE: state_in = dec_next;
         EX_RDB:    state_in = div_zero ? EX_FINISH : EX_RDA;
         EX_RDA:    state_in = EX_ALU;
         EX_ALU:    state_in = EX_WAIT;
         EX_WAIT:   if (alu_rsp.done) state_in = EX_FINISH;
         EX_LOAD, EX_STORE, EX_POPTOP: state_in = EX_FINISH;
         EX_FINISH: if (rsp_free) state_in = EX_IDLE;
         default:   state_in = EX_IDLE;
      endcase
   end

   // Datapath and memory controls
   always_comb begin
      op_in         = op_ff;
      arg_in        = arg_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      cnt_in        = cnt_ff;
      pc_in         = pc_ff;
      npc_in        = npc_ff;
      stop_in       = stop_ff;
      status_in     = status_ff;
      pvalid_in     = pvalid_ff;
      pval_in       = pval_ff;
      clr_in        = clr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_npc_in    = rsp_npc_ff;
      rsp_pv_in     = rsp_pv_ff;
      rsp_pval_in   = rsp_pval_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      stk_we        = 1'b0;
      stk_wa        = cnt_ff[SAW-1:0];
      stk_wd        = arg_ff;
      slot_we       = 1'b0;
      slot_wa       = arg_ff[SLAW-1:0];
      slot_wd       = stk_rd;
      unique case (state_ff)
         EX_CLEAR: begin
            // zero the slot memory after reset
            slot_we = 1'b1;
            slot_wa = clr_ff;
            slot_wd = '0;
            clr_in  = clr_ff + SLAW'(1);
         end
         EX_IDLE: begin
            if (req_take) begin
               op_in  = req_opcode;
               arg_in = req_operand;
            end
         end
         EX_DECODE: begin
            status_in = dec_status;
            npc_in    = pc_ff + PC_W'(1);
            pvalid_in = 1'b0;
            pval_in   = '0;
            if (dec_status == ST_OK) begin
               priority case (op_ff)
                  OP_PUSH: begin
                     stk_we = 1'b1;
                     cnt_in = cnt_ff + CNT_W'(1);
                  end
                  OP_POP:  cnt_in = cnt_m1;
                  OP_JUMP: npc_in = arg_ff[PC_W-1:0];
                  default: begin
                  end
               endcase
            end
         end
         EX_RDB: begin
            b_in = stk_rd;
            if (div_zero) begin
               status_in = (op_ff == OP_DIV) ? ST_DIV_ZERO : ST_MOD_ZERO;
            end
         end
         EX_RDA: a_in = stk_rd;
         EX_ALU: begin
         end
         EX_WAIT: begin
            if (alu_rsp.done) begin
               stk_we = 1'b1;
               stk_wa = cnt_m2[SAW-1:0];
               stk_wd = alu_rsp.result;
               cnt_in = cnt_m1;
            end
         end
         EX_LOAD: begin
            stk_we = 1'b1;
            stk_wd = slot_rd;
            cnt_in = cnt_ff + CNT_W'(1);
         end
         EX_STORE: begin
            slot_we = 1'b1;
            cnt_in  = cnt_m1;
         end
         EX_POPTOP: begin
            cnt_in = cnt_m1;
            if (op_ff == OP_EMIT) begin
               pvalid_in = 1'b1;
               pval_in   = stk_rd;
            end else if (stk_rd == '0) begin
               if (!target_ok) status_in = ST_BAD_TARGET;
               else npc_in = arg_ff[PC_W-1:0];
            end
         end
         EX_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_pv_in     = pvalid_ff;
               rsp_pval_in   = pval_ff;
               if (status_ff == ST_OK) begin
                  rsp_npc_in = npc_ff;
                  pc_in      = npc_ff;
               end else begin
                  rsp_npc_in = pc_ff;
                  stop_in    = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Program length register, saturated to the limit
   always_comb begin
      len_in = len_ff;
      if (csr_valid && csr_ready) begin
         len_in = (32'(csr_data) > 32'(PROGRAM_LIMIT)) ? PC_W'(PROGRAM_LIMIT) : csr_data;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= EX_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         pc_ff        <= '0;
         stop_ff      <= 1'b0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         pc_ff        <= pc_in;
         stop_ff      <= stop_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      arg_ff        <= arg_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      npc_ff        <= npc_in;
      status_ff     <= status_in;
      pvalid_ff     <= pvalid_in;
      pval_ff       <= pval_in;
      rsp_status_ff <= rsp_status_in;
      rsp_npc_ff    <= rsp_npc_in;
      rsp_pv_ff     <= rsp_pv_in;
      rsp_pval_ff   <= rsp_pval_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_next_pc     = rsp_npc_ff;
   assign rsp_print_valid = rsp_pv_ff;
   assign rsp_print_value = rsp_pval_ff;

   // Assertions
`include "stack_machine_executor_top_assert.svh"

   `SMX_ASSERT_IMPLY(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(STACK_DEPTH))
   `SMX_ASSERT_NEXT(a_stop_sticky, clock, reset, stop_ff, stop_ff)
   `SMX_ASSERT_NEXT(a_pc_at_finish, clock, reset, state_ff != EX_FINISH, $stable(pc_ff))
   `SMX_ASSERT_IMPLY(a_alu_done_wait, clock, reset, alu_rsp.done, state_ff == EX_WAIT)

endmodule

### rtl/core/smx_ram.sv
// ----------------------------------------------------------------------------
// smx_ram
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module smx_ram #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [63:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [63:0]   rd_data
);

   logic [63:0] mem [DEPTH];
   logic [63:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/smx_alu.sv
// ----------------------------------------------------------------------------
// smx_alu
// Shared 65-bit adder under a small sequencer: add, subtract and compares
// computed on start; shift-add multiply and restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
module smx_alu (
   input  logic                clock,
   input  logic                reset,
   input  smx_pkg::alu_cmd_type cmd,
   input  logic [63:0]         a,
   input  logic [63:0]         b,
   output smx_pkg::alu_rsp_type rsp
);

   import smx_pkg::*;

   alu_state_type     state_ff, state_in;
   alu_op_type        op_ff, op_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] opa_ff, opa_in;
   logic [DATA_W-1:0] opb_ff, opb_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              neg_ff, neg_in;

   logic [DATA_W:0]   add_x, add_y;
   logic              add_ci;
   logic [DATA_W+1:0] add_s;
   logic              last_step;
   logic [DATA_W-1:0] fix_val;

   // The one shared adder
   assign add_s = {1'b0, add_x} + {1'b0, add_y} + {{(DATA_W+1){1'b0}}, add_ci};

   assign last_step = (cnt_ff == STEP_W'(DATA_W - 1));
   assign fix_val   = (op_ff == ALU_DIV) ? opa_ff : acc_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         AL_IDLE: begin
            if (cmd.start) begin
               priority case (cmd.op)
                  ALU_MUL:          state_in = AL_ITER;
                  ALU_DIV, ALU_MOD: state_in = AL_NEGA;
                  default:          state_in = AL_DONE;
               endcase
            end
         end
         AL_NEGA: state_in = AL_NEGB;
         AL_NEGB: state_in = AL_ITER;
         AL_ITER: begin
            if (last_step) begin
               state_in = (op_ff == ALU_MUL) ? AL_DONE : AL_FIX;
            end
         end
         AL_FIX:  state_in = AL_DONE;
         AL_DONE: state_in = AL_IDLE;
         default: state_in = AL_IDLE;
      endcase
   end

   // Datapath
   always_comb begin
      op_in  = op_ff;
      acc_in = acc_ff;
      opa_in = opa_ff;
      opb_in = opb_ff;
      res_in = res_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      add_x  = '0;
      add_y  = '0;
      add_ci = 1'b0;
      unique case (state_ff)
         AL_IDLE: begin
            if (cmd.start) begin
               op_in  = cmd.op;
               cnt_in = '0;
               acc_in = '0;
               opa_in = a;
               opb_in = b;
               neg_in = (cmd.op == ALU_DIV) ? (a[DATA_W-1] ^ b[DATA_W-1]) : a[DATA_W-1];
               unique case (cmd.op)
                  ALU_ADD: begin
                     add_x  = {1'b0, a};
                     add_y  = {1'b0, b};
                     res_in = add_s[DATA_W-1:0];
                  end
                  ALU_SUB, ALU_EQ, ALU_NE: begin
                     add_x  = {1'b0, a};
                     add_y  = ~{1'b0, b};
                     add_ci = 1'b1;
                     if (cmd.op == ALU_SUB) begin
                        res_in = add_s[DATA_W-1:0];
                     end else if (cmd.op == ALU_EQ) begin
                        res_in = {{(DATA_W-1){1'b0}}, (add_s[DATA_W-1:0] == '0)};
                     end else begin
                        res_in = {{(DATA_W-1){1'b0}}, (add_s[DATA_W-1:0] != '0)};
                     end
                  end
                  ALU_SLT, ALU_SGE: begin
                     // signed compare via sign-flipped unsigned subtract
                     add_x  = {1'b0, a ^ SIGN_MASK};
                     add_y  = ~{1'b0, b ^ SIGN_MASK};
                     add_ci = 1'b1;
                     res_in = {{(DATA_W-1){1'b0}},
                               (cmd.op == ALU_SGE) ? add_s[DATA_W+1] : ~add_s[DATA_W+1]};
                  end
                  default: begin
                  end
               endcase
            end
         end
         AL_NEGA: begin
            // magnitude of the dividend
            add_x  = {1'b0, ~opa_ff};
            add_ci = 1'b1;
            if (opa_ff[DATA_W-1]) begin
               opa_in = add_s[DATA_W-1:0];
            end
         end
         AL_NEGB: begin
            // magnitude of the divisor
            add_x  = {1'b0, ~opb_ff};
            add_ci = 1'b1;
            if (opb_ff[DATA_W-1]) begin
               opb_in = add_s[DATA_W-1:0];
            end
         end
         AL_ITER: begin
            cnt_in = cnt_ff + STEP_W'(1);
            if (op_ff == ALU_MUL) begin
               add_x  = {1'b0, acc_ff};
               add_y  = {1'b0, opa_ff};
               if (opb_ff[0]) begin
                  acc_in = add_s[DATA_W-1:0];
               end
               opa_in = {opa_ff[DATA_W-2:0], 1'b0};
               opb_in = {1'b0, opb_ff[DATA_W-1:1]};
               if (last_step) begin
                  res_in = acc_in;
               end
            end else begin
               // restoring divide step: trial subtract of the divisor
               add_x  = {acc_ff, opa_ff[DATA_W-1]};
               add_y  = ~{1'b0, opb_ff};
               add_ci = 1'b1;
               if (add_s[DATA_W+1]) begin
                  acc_in = add_s[DATA_W-1:0];
                  opa_in = {opa_ff[DATA_W-2:0], 1'b1};
               end else begin
                  acc_in = {acc_ff[DATA_W-2:0], opa_ff[DATA_W-1]};
                  opa_in = {opa_ff[DATA_W-2:0], 1'b0};
               end
            end
         end
         AL_FIX: begin
            // apply the sign to quotient or remainder
            add_x  = {1'b0, ~fix_val};
            add_ci = 1'b1;
            res_in = neg_ff ? add_s[DATA_W-1:0] : fix_val;
         end
         AL_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      res_ff <= res_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign rsp.done   = (state_ff == AL_DONE);
   assign rsp.result = res_ff;

endmodule
